// ===== rtl/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types, codes and constants of the byte stream segmenter.
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_SPLIT_MODE        = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_SIZE      = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER_LENGTH  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER_PATTERN = 8'd3;

    localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;
    localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        SPLIT_ON_BYTE      = 2'd0,
        SPLIT_ON_NEWLINE   = 2'd1,
        SPLIT_ON_DELIMITER = 2'd2
    } split_mode_t;

    typedef struct packed {
        logic push;
        logic clear;
    } win_ctrl_t;

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

// ===== rtl/bss_in_if.sv =====
// ----------------------------------------------------------------------------
// bss_in_if
// Input byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/bss_out_if.sv =====
// ----------------------------------------------------------------------------
// bss_out_if
// Output channel carrying one byte with its segment index and flags.
// ----------------------------------------------------------------------------
interface bss_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [31:0] segment_index;
    logic        segment_first;
    logic        segment_last;

    modport source (output valid, output out_byte, output segment_index,
                    output segment_first, output segment_last, input ready);
    modport sink   (input valid, input out_byte, input segment_index,
                    input segment_first, input segment_last, output ready);
endinterface

// ===== rtl/bss_window.sv =====
// ----------------------------------------------------------------------------
// bss_window
// Sliding byte window with fill count and parallel delimiter compare.
// ----------------------------------------------------------------------------
module bss_window #(
    parameter int unsigned MAX_DELIMITER_BYTES = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bss_pkg::win_ctrl_t   ctrl,
    input  logic [7:0]           in_byte,
    input  logic [3:0]           delimiter_length,
    input  logic [63:0]          delimiter_pattern,
    output logic                 match
);
    localparam int unsigned FILL_W = $clog2(MAX_DELIMITER_BYTES + 1);

    logic [7:0]        win_reg  [MAX_DELIMITER_BYTES];
    logic [7:0]        win_next [MAX_DELIMITER_BYTES];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [3:0]        eff_len;
    logic [MAX_DELIMITER_BYTES:1] len_eq;
    logic              sel_eq;

    always_comb
    begin
        win_next[0] = in_byte;
        for (int k = 1; k < MAX_DELIMITER_BYTES; k++)
        begin
            win_next[k] = win_reg[k-1];
        end
        if (fill_reg < FILL_W'(MAX_DELIMITER_BYTES))
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    always_comb
    begin
        for (int l = 1; l <= MAX_DELIMITER_BYTES; l++)
        begin
            len_eq[l] = 1'b1;
            for (int k = 0; k < l; k++)
            begin
                if (win_next[l-1-k] != delimiter_pattern[8*k +: 8])
                begin
                    len_eq[l] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        if (delimiter_length > 4'(MAX_DELIMITER_BYTES))
        begin
            eff_len = 4'(MAX_DELIMITER_BYTES);
        end
        else
        begin
            eff_len = delimiter_length;
        end
        sel_eq = 1'b0;
        for (int l = 1; l <= MAX_DELIMITER_BYTES; l++)
        begin
            if (eff_len == 4'(l))
            begin
                sel_eq = len_eq[l];
            end
        end
        match = (eff_len != 4'd0) && (4'(fill_next) >= eff_len) && sel_eq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int k = 0; k < MAX_DELIMITER_BYTES; k++)
            begin
                win_reg[k] <= 8'd0;
            end
        end
        else if (ctrl.clear)
        begin
            fill_reg <= '0;
            for (int k = 0; k < MAX_DELIMITER_BYTES; k++)
            begin
                win_reg[k] <= 8'd0;
            end
        end
        else if (ctrl.push)
        begin
            fill_reg <= fill_next;
            for (int k = 0; k < MAX_DELIMITER_BYTES; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

endmodule

// ===== rtl/byte_stream_segmenter.sv =====
// ----------------------------------------------------------------------------
// byte_stream_segmenter
// Passes bytes through and tags each with its segment index and boundary
// flags; segments close on a byte, newline or delimiter count.
// ----------------------------------------------------------------------------
//  channel    | dir | payload                                      | handshake
//  in_stream  | in  | in_byte                                      | valid/ready
//  out_stream | out | out_byte, segment_index, segment_first/last  | valid/ready
//  cfg        | in  | cfg_index, cfg_data                          | cfg_we
//
//  One word per cycle unless the output stalls: a byte is accepted, counted
//  and matched in the same cycle and its result is held in the output register.
//  Output valid rises in the cycle after input acceptance.
//  The input stays ready while the output register is empty or being taken.
//  Reset clears the window, the counters and loads register defaults.
// ----------------------------------------------------------------------------
module byte_stream_segmenter #(
    parameter int unsigned MAX_DELIMITER_BYTES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    bss_in_if.sink                              in_stream,
    bss_out_if.source                           out_stream,
    input  logic                                cfg_we,
    input  logic [bss_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bss_pkg::CFG_DATA_W-1:0]      cfg_data
);
    bss_pkg::split_mode_t split_mode_reg;
    logic [31:0]          segment_size_reg;
    logic [3:0]           delimiter_length_reg;
    logic [63:0]          delimiter_pattern_reg;

    logic        open_reg;
    logic [31:0] unit_count_reg;
    logic [31:0] counter_reg;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [31:0] out_index_reg;
    logic        out_first_reg;
    logic        out_last_reg;

    logic               in_fire;
    logic               first;
    logic               unit;
    logic               last;
    logic               match;
    logic [31:0]        counter_next;
    logic [31:0]        index;
    logic [31:0]        count_base;
    logic [31:0]        count_new;
    bss_pkg::win_ctrl_t win_ctrl;

    assign in_stream.ready = !out_valid_reg || out_stream.ready;
    assign in_fire         = in_stream.valid && in_stream.ready;

    assign out_stream.valid         = out_valid_reg;
    assign out_stream.out_byte      = out_byte_reg;
    assign out_stream.segment_index = out_index_reg;
    assign out_stream.segment_first = out_first_reg;
    assign out_stream.segment_last  = out_last_reg;

    bss_window #(
        .MAX_DELIMITER_BYTES (MAX_DELIMITER_BYTES)
    ) u_window (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (win_ctrl),
        .in_byte           (in_stream.in_byte),
        .delimiter_length  (delimiter_length_reg),
        .delimiter_pattern (delimiter_pattern_reg),
        .match             (match)
    );

    always_comb
    begin
        first = !open_reg;
        counter_next = first ? bss_pkg::sat_inc(counter_reg) : counter_reg;
        if (first)
        begin
            index = counter_reg;
        end
        else if (counter_reg == bss_pkg::COUNT_MAX)
        begin
            index = bss_pkg::COUNT_MAX;
        end
        else if (counter_reg == 32'd0)
        begin
            index = 32'd0;
        end
        else
        begin
            index = counter_reg - 32'd1;
        end

        case (split_mode_reg)
            bss_pkg::SPLIT_ON_BYTE:      unit = 1'b1;
            bss_pkg::SPLIT_ON_NEWLINE:   unit = (in_stream.in_byte == bss_pkg::NEWLINE_BYTE);
            bss_pkg::SPLIT_ON_DELIMITER: unit = match;
            default:                     unit = 1'b0;
        endcase

        count_base = first ? 32'd0 : unit_count_reg;
        count_new  = unit ? bss_pkg::sat_inc(count_base) : count_base;
        last       = (count_new >= segment_size_reg);

        win_ctrl.push  = in_fire && (split_mode_reg == bss_pkg::SPLIT_ON_DELIMITER);
        win_ctrl.clear = in_fire && last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_mode_reg        <= bss_pkg::SPLIT_ON_BYTE;
            segment_size_reg      <= 32'd1;
            delimiter_length_reg  <= 4'd1;
            delimiter_pattern_reg <= 64'h0A;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bss_pkg::REG_SPLIT_MODE:
                    split_mode_reg <= bss_pkg::split_mode_t'(cfg_data[1:0]);
                bss_pkg::REG_SEGMENT_SIZE:
                    segment_size_reg <= cfg_data[31:0];
                bss_pkg::REG_DELIMITER_LENGTH:
                    delimiter_length_reg <= cfg_data[3:0];
                bss_pkg::REG_DELIMITER_PATTERN:
                    delimiter_pattern_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= 1'b0;
            unit_count_reg <= 32'd0;
            counter_reg    <= 32'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                open_reg       <= !last;
                unit_count_reg <= last ? 32'd0 : count_new;
                counter_reg    <= counter_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_byte_reg  <= in_stream.in_byte;
            out_index_reg <= index;
            out_first_reg <= first;
            out_last_reg  <= last;
        end
    end

    a_first_flag: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !open_reg |=> out_valid_reg && out_first_reg)
        else $error("Segment opened without first flag.");

    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last |=> !open_reg && (unit_count_reg == 32'd0) && out_last_reg)
        else $error("Segment did not close after last word.");

    a_open_counted: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (counter_reg != 32'd0))
        else $error("Open segment with zero segment counter.");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire && out_stream.ready |=> !out_valid_reg)
        else $error("Output word not released after being taken.");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte stream segmenter. A directed table covers
// reset values, boundary bytes, all split modes and the corner cases of the
// register set. Randomized phases follow, each with its own register setting
// and idling profile. Each output word is compared with its checked row or a
// local model of the segment counter, the unit count and the delimiter window.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_DELIM = 8;
    localparam int PHASE_ITEMS = 206;
    localparam int NUM_ROWS = 34;
    localparam int NUM_PHASES = 9;
    localparam int LONG_HOLD_CYCLES = 300;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [bss_pkg::CFG_INDEX_W-1:0] REG_UNKNOWN = 8'd4;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_BYTE,
        ROW_BYTE_CHECKED
    } row_kind_t;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [bss_pkg::CFG_INDEX_W-1:0] reg_index;
        logic [63:0]                     value;
        logic [31:0]                     seg_idx;
        logic                            first;
        logic                            last;
    } stim_row_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] size;
        logic [3:0]  dlen;
        logic        random_pattern;
        logic [63:0] pattern;
        idle_t       idle;
        logic        pressure;
    } phase_t;

    typedef struct packed {
        logic [7:0]  data;
        logic [31:0] idx;
        logic        first;
        logic        last;
    } seg_word_t;

    localparam stim_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        '{ROW_BYTE_CHECKED, 8'd0, 64'h00, 32'd0, 1'b1, 1'b1},
        '{ROW_BYTE_CHECKED, 8'd0, 64'hFF, 32'd1, 1'b1, 1'b1},
        '{ROW_BYTE_CHECKED, 8'd0, 64'h0A, 32'd2, 1'b1, 1'b1},
        '{ROW_WRITE, bss_pkg::REG_SEGMENT_SIZE, 64'd0, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE_CHECKED, 8'd0, 64'h55, 32'd3, 1'b1, 1'b1},
        '{ROW_WRITE, bss_pkg::REG_SPLIT_MODE, {62'd0, bss_pkg::SPLIT_ON_NEWLINE},
          32'd0, 1'b0, 1'b0},
        '{ROW_WRITE, bss_pkg::REG_SEGMENT_SIZE, 64'd2, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE_CHECKED, 8'd0, 64'h41, 32'd4, 1'b1, 1'b0},
        '{ROW_BYTE_CHECKED, 8'd0, 64'h0A, 32'd4, 1'b0, 1'b0},
        '{ROW_BYTE_CHECKED, 8'd0, 64'h0A, 32'd4, 1'b0, 1'b1},
        '{ROW_WRITE, bss_pkg::REG_SPLIT_MODE, {62'd0, MODE_UNUSED}, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'd0, 64'h0A, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'd0, 64'hFF, 32'd0, 1'b0, 1'b0},
        '{ROW_WRITE, bss_pkg::REG_SPLIT_MODE, {62'd0, bss_pkg::SPLIT_ON_DELIMITER},
          32'd0, 1'b0, 1'b0},
        '{ROW_WRITE, bss_pkg::REG_SEGMENT_SIZE, 64'd1, 32'd0, 1'b0, 1'b0},
        '{ROW_WRITE, bss_pkg::REG_DELIMITER_LENGTH, 64'd2, 32'd0, 1'b0, 1'b0},
        '{ROW_WRITE, bss_pkg::REG_DELIMITER_PATTERN, 64'h0A0D, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'd0, 64'h0D, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'd0, 64'h0A, 32'd0, 1'b0, 1'b0},
        '{ROW_WRITE, bss_pkg::REG_DELIMITER_LENGTH, 64'd15, 32'd0, 1'b0, 1'b0},
        '{ROW_WRITE, bss_pkg::REG_DELIMITER_PATTERN, 64'h0102_0304_0506_0708,
          32'd0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'd0, 64'h08, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'd0, 64'h07, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'd0, 64'h06, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'd0, 64'h05, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'd0, 64'h04, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'd0, 64'h03, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'd0, 64'h02, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'd0, 64'h01, 32'd0, 1'b0, 1'b0},
        '{ROW_WRITE, bss_pkg::REG_DELIMITER_LENGTH, 64'd0, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'd0, 64'h0A, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'd0, 64'h00, 32'd0, 1'b0, 1'b0},
        '{ROW_WRITE, REG_UNKNOWN, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, 1'b0},
        '{ROW_BYTE, 8'd0, 64'h0A, 32'd0, 1'b0, 1'b0}
    };

    localparam phase_t PHASES [0:NUM_PHASES-1] = '{
        '{bss_pkg::SPLIT_ON_BYTE, 32'd3, 4'd1, 1'b1, 64'd0, IDLE_NONE, 1'b0},
        '{bss_pkg::SPLIT_ON_NEWLINE, 32'd2, 4'd1, 1'b0, 64'h0A, IDLE_SENDER, 1'b0},
        '{bss_pkg::SPLIT_ON_DELIMITER, 32'd1, 4'd3, 1'b1, 64'd0, IDLE_RECEIVER, 1'b1},
        '{bss_pkg::SPLIT_ON_DELIMITER, 32'd2, 4'd8, 1'b1, 64'd0, IDLE_BOTH, 1'b0},
        '{bss_pkg::SPLIT_ON_BYTE, 32'hFFFF_FFFF, 4'd15, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
          IDLE_NONE, 1'b0},
        '{bss_pkg::SPLIT_ON_DELIMITER, 32'd3, 4'd1, 1'b0, 64'h0A, IDLE_SENDER, 1'b0},
        '{bss_pkg::SPLIT_ON_NEWLINE, 32'd1, 4'd2, 1'b0, 64'd0, IDLE_RECEIVER, 1'b0},
        '{bss_pkg::SPLIT_ON_DELIMITER, 32'd1, 4'd5, 1'b1, 64'd0, IDLE_BOTH, 1'b0},
        '{MODE_UNUSED, 32'd0, 4'd0, 1'b1, 64'd0, IDLE_BOTH, 1'b0}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [bss_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bss_pkg::CFG_DATA_W-1:0]  cfg_data;

    bss_in_if  in_if ();
    bss_out_if out_if ();

    byte_stream_segmenter #(
        .MAX_DELIMITER_BYTES (MAX_DELIM)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    logic [1:0]  cur_mode;
    logic [31:0] cur_size;
    logic [3:0]  cur_dlen;
    logic [63:0] cur_pattern;

    logic        seg_open;
    logic [31:0] unit_count;
    logic [31:0] seg_count;
    logic [7:0]  win [MAX_DELIM];
    int          win_fill;

    seg_word_t   expected_words [$];
    int          mismatch_count;
    int          send_gap_pct;
    int          recv_stall_pct;
    bit          hold_armed;
    bit          hold_done;
    int          hold_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic seg_word_t segment_next_byte(input logic [7:0] b);
        seg_word_t w;
        logic      unit;
        logic      hit;
        int        len;
        w.data  = b;
        w.first = 1'b0;
        w.last  = 1'b0;
        unit    = 1'b0;
        if (!seg_open)
        begin
            seg_open   = 1'b1;
            unit_count = '0;
            w.first    = 1'b1;
            w.idx      = seg_count;
            if (seg_count != bss_pkg::COUNT_MAX)
                seg_count = seg_count + 32'd1;
        end
        else
        begin
            w.idx = (seg_count == 32'd0) ? 32'd0 : seg_count - 32'd1;
        end
        if (seg_count == bss_pkg::COUNT_MAX && !w.first)
            w.idx = bss_pkg::COUNT_MAX;
        case (cur_mode)
            bss_pkg::SPLIT_ON_BYTE:    unit = 1'b1;
            bss_pkg::SPLIT_ON_NEWLINE: unit = (b == bss_pkg::NEWLINE_BYTE);
            bss_pkg::SPLIT_ON_DELIMITER:
            begin
                for (int k = MAX_DELIM - 1; k > 0; k--)
                    win[k] = win[k-1];
                win[0] = b;
                if (win_fill < MAX_DELIM)
                    win_fill++;
                len = (cur_dlen > MAX_DELIM) ? MAX_DELIM : int'(cur_dlen);
                hit = (len != 0) && (win_fill >= len);
                for (int k = 0; k < len; k++)
                    if (win[len-1-k] != cur_pattern[8*k +: 8])
                        hit = 1'b0;
                unit = hit;
            end
            default: unit = 1'b0;
        endcase
        if (unit && unit_count != bss_pkg::COUNT_MAX)
            unit_count = unit_count + 32'd1;
        if (unit_count >= cur_size)
        begin
            w.last     = 1'b1;
            seg_open   = 1'b0;
            unit_count = '0;
            win        = '{default: 8'h00};
            win_fill   = 0;
        end
        return w;
    endfunction

    task automatic write_reg(input logic [bss_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            bss_pkg::REG_SPLIT_MODE:        cur_mode = value[1:0];
            bss_pkg::REG_SEGMENT_SIZE:      cur_size = value[31:0];
            bss_pkg::REG_DELIMITER_LENGTH:  cur_dlen = value[3:0];
            bss_pkg::REG_DELIMITER_PATTERN: cur_pattern = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic send_word(input logic [7:0] b, input bit typed, input seg_word_t typed_word);
        seg_word_t w;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        do
            @(posedge clk);
        while (in_if.ready !== 1'b1);
        w = segment_next_byte(b);
        if (typed)
            w = typed_word;
        expected_words.push_back(w);
        @(negedge clk);
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_word(b, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        seg_word_t w;
        if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        begin
            if (expected_words.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected word byte=%02h", out_if.out_byte));
            end
            else
            begin
                w = expected_words.pop_front();
                if (out_if.out_byte !== w.data)
                    flag_mismatch($sformatf("out_byte %02h, want %02h",
                                            out_if.out_byte, w.data));
                if (out_if.segment_index !== w.idx)
                    flag_mismatch($sformatf("segment_index %0d, want %0d",
                                            out_if.segment_index, w.idx));
                if (out_if.segment_first !== w.first)
                    flag_mismatch($sformatf("segment_first %b, want %b",
                                            out_if.segment_first, w.first));
                if (out_if.segment_last !== w.last)
                    flag_mismatch($sformatf("segment_last %b, want %b",
                                            out_if.segment_last, w.last));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_if.ready <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end
        else
        begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        stim_row_t   row;
        phase_t      ph;
        seg_word_t   tw;
        int          sent;
        int          len;
        int          roll;
        int          cut;
        logic [63:0] pat;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_if.valid    = 1'b0;
        in_if.in_byte  = '0;
        out_if.ready   = 1'b1;
        mismatch_count = 0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_armed     = 1'b0;
        hold_done      = 1'b0;
        hold_left      = 0;
        cur_mode       = bss_pkg::SPLIT_ON_BYTE;
        cur_size       = 32'd1;
        cur_dlen       = 4'd1;
        cur_pattern    = {56'd0, bss_pkg::NEWLINE_BYTE};
        seg_open       = 1'b0;
        unit_count     = '0;
        seg_count      = '0;
        win            = '{default: 8'h00};
        win_fill       = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_WRITE)
            begin
                in_if.valid <= 1'b0;
                wait_idle();
                write_reg(row.reg_index, row.value);
            end
            else
            begin
                tw = '{data: row.value[7:0], idx: row.seg_idx,
                       first: row.first, last: row.last};
                send_word(row.value[7:0], row.kind == ROW_BYTE_CHECKED, tw);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            ph = PHASES[p];
            in_if.valid <= 1'b0;
            wait_idle();
            pat = ph.random_pattern ? {$urandom, $urandom} : ph.pattern;
            write_reg(bss_pkg::REG_SPLIT_MODE, {62'd0, ph.mode});
            write_reg(bss_pkg::REG_SEGMENT_SIZE, {32'd0, ph.size});
            write_reg(bss_pkg::REG_DELIMITER_LENGTH, {60'd0, ph.dlen});
            write_reg(bss_pkg::REG_DELIMITER_PATTERN, pat);
            case (ph.idle)
                IDLE_SENDER:   begin send_gap_pct = 57; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 57; end
                IDLE_BOTH:     begin send_gap_pct = 30; recv_stall_pct = 30; end
                default:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            endcase
            if (ph.pressure)
                hold_armed = 1'b1;
            len  = (cur_dlen > MAX_DELIM) ? MAX_DELIM : int'(cur_dlen);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                if (cur_mode == bss_pkg::SPLIT_ON_DELIMITER && len != 0 && roll < 50)
                begin
                    for (int k = 0; k < len; k++)
                        send_plain(cur_pattern[8*k +: 8]);
                    sent += len;
                end
                else if (cur_mode == bss_pkg::SPLIT_ON_DELIMITER && len > 1 && roll < 65)
                begin
                    cut = $urandom_range(len - 1, 1);
                    for (int k = 0; k < cut; k++)
                        send_plain(cur_pattern[8*k +: 8]);
                    sent += cut;
                end
                else if (cur_mode == bss_pkg::SPLIT_ON_DELIMITER && len != 0 && roll < 80)
                begin
                    send_plain(cur_pattern[8*$urandom_range(len - 1) +: 8]);
                    sent++;
                end
                else if (cur_mode == bss_pkg::SPLIT_ON_NEWLINE && roll < 25)
                begin
                    send_plain(bss_pkg::NEWLINE_BYTE);
                    sent++;
                end
                else
                begin
                    send_plain(8'($urandom));
                    sent++;
                end
            end
        end

        in_if.valid <= 1'b0;
        for (int i = 0; i < 5000 && expected_words.size() != 0; i++)
            @(negedge clk);
        repeat (5) @(negedge clk);
        if (expected_words.size() != 0)
            flag_mismatch($sformatf("%0d expected words never arrived",
                                    expected_words.size()));
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
